// ----- rtl/keyframe_point_interpolator_macros.svh -----
// ----------------------------------------------------------------------------
// keyframe point interpolator assertion macros
// shared concurrent assertion forms, clocked with async active-low reset
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_POINT_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_POINT_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define KPI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/kpi_pkg.sv -----
// ----------------------------------------------------------------------------
// kpi_pkg
// types, constants and arithmetic helpers of the keyframe point interpolator
// ----------------------------------------------------------------------------
package kpi_pkg;

	localparam int MAX_KEYS_DEF = 64;
	localparam int KEY_COUNT_W  = 7;
	localparam int DIV_NW       = 49;
	localparam int DIV_DW       = 33;
	localparam logic signed [32:0] Q_ONE = 33'sd65536;

	typedef enum logic [2:0] {
		FN_CLEAR  = 3'd0,
		FN_ADD    = 3'd1,
		FN_EVAL   = 3'd2,
		FN_OFFSET = 3'd3,
		FN_SCALE  = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BEFORE = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {RD_I, RD_B, RD_ZERO} rd_sel_t;
	typedef enum logic [1:0] {SRC_RAM, SRC_CUR, SRC_DIFF} src_t;
	typedef enum logic [1:0] {B_VEC, B_ONE, B_RATIO} bsel_t;
	typedef enum logic [1:0] {ADD_ZERO, ADD_VEC, ADD_P0} asel_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_MOD, S_T0_RD, S_T0_CHK, S_SCAN_RD, S_SCAN_CHK,
		S_RATIO, S_P0_RD, S_P0_LD, S_P1_LD, S_LERP_MUL, S_HOLD_RD, S_HOLD_LD,
		S_KEY_RD, S_KEY_LD, S_KEY_WR, S_PT_MUL, S_CUR_WR, S_FINISH
	} state_t;

	typedef struct packed {
		logic    load;
		logic    clr_keys;
		logic    add_key;
		logic    st_en;
		status_t st;
		logic    div_mod;
		logic    div_ratio;
		logic    mod_done;
		logic    ratio_done;
		rd_sel_t rd_sel;
		logic    idx_clr;
		logic    idx_one;
		logic    idx_inc;
		logic    b_take;
		logic    tb_load;
		logic    mul_en;
		src_t    mul_src;
		bsel_t   mul_b;
		asel_t   mul_add;
		logic    key_wr;
		logic    cur_wr;
		logic    p0_load;
		logic    diff_load;
		logic    res_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       empty;
		logic       full;
		logic       single;
		logic       last_i;
		logic       loop_wrap;
		logic       div_done;
		logic       before_first;
		logic       bracket;
		logic       zero_span;
	} stat_t;

	// product / 65536 truncated toward zero, plus addend, saturated to 32 bits
	function automatic logic signed [31:0] sat_round(input logic signed [65:0] prod,
			input logic signed [32:0] addend);
		logic signed [65:0] adj;
		logic signed [49:0] q;
		logic signed [50:0] sum;
		adj = prod + (prod[65] ? 66'sd65535 : 66'sd0);
		q   = adj[65:16];
		sum = 51'(q) + 51'(addend);
		if (sum > 51'sd2147483647) begin
			sat_round = 32'sh7FFFFFFF;
		end else if (sum < -51'sd2147483648) begin
			sat_round = 32'sh80000000;
		end else begin
			sat_round = sum[31:0];
		end
	endfunction

endpackage

// ----- rtl/kpi_if.sv -----
// ----------------------------------------------------------------------------
// kpi item and result channels
// valid/ready channels carrying the input item and the result item
// ----------------------------------------------------------------------------
interface kpi_item_if;
	logic               valid;
	logic               ready;
	logic [2:0]         func;
	logic signed [31:0] time_value;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;
	modport source (output valid, func, time_value, vec_x, vec_y, vec_z, input ready);
	modport sink (input valid, func, time_value, vec_x, vec_y, vec_z, output ready);
endinterface

interface kpi_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [1:0]         status;
	logic signed [31:0] duration;
	logic [6:0]         key_count;
	modport source (output valid, pos_x, pos_y, pos_z, status, duration, key_count,
		input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, status, duration, key_count,
		output ready);
endinterface

// ----- rtl/kpi_ram.sv -----
// ----------------------------------------------------------------------------
// kpi_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module kpi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/kpi_div.sv -----
// ----------------------------------------------------------------------------
// kpi_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kpi_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [kpi_pkg::DIV_NW-1:0]  num,
	input  logic [kpi_pkg::DIV_DW-1:0]  den,
	output logic                        done,
	output logic [kpi_pkg::DIV_NW-1:0]  quo,
	output logic [kpi_pkg::DIV_DW-1:0]  rem
);
	localparam int NW = kpi_pkg::DIV_NW;
	localparam int DW = kpi_pkg::DIV_DW;
	localparam int CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

// ----- rtl/kpi_datapath.sv -----
// ----------------------------------------------------------------------------
// kpi_datapath
// key memories, current point, three multiply lanes, divider and result register
// ----------------------------------------------------------------------------
`include "keyframe_point_interpolator_macros.svh"

module kpi_datapath #(
	parameter int MAX_KEYS = kpi_pkg::MAX_KEYS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kpi_pkg::cmd_t      cmd,
	output kpi_pkg::stat_t     stat,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic [2:0]         func,
	input  logic signed [31:0] time_value,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic [1:0]         status,
	output logic signed [31:0] duration,
	output logic [6:0]         key_count
);
	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = $clog2(MAX_KEYS + 1);

	logic [2:0]         func_q;
	logic signed [31:0] t_q;
	logic signed [31:0] vec_q [3];
	logic signed [31:0] vec_in [3];
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      i_q;
	logic [CW-1:0]      b_q;
	logic signed [31:0] dur_q;
	logic signed [31:0] tb_q;
	logic               loop_q;
	logic signed [31:0] cur_q [3];
	logic signed [31:0] p0_q [3];
	logic signed [32:0] diff_q [3];
	logic [16:0]        r_q;
	kpi_pkg::status_t   status_q;
	logic signed [65:0] prod_s1 [3];
	logic signed [32:0] add_s1 [3];
	logic signed [32:0] mul_a [3];
	logic signed [32:0] mul_b [3];
	logic signed [32:0] mul_c [3];
	logic signed [31:0] lane_res [3];
	logic signed [31:0] ram_rd [3];
	logic signed [31:0] time_rd;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      lane_waddr;
	logic               lane_we;

	// divider
	logic [kpi_pkg::DIV_NW-1:0] div_num;
	logic [kpi_pkg::DIV_DW-1:0] div_den;
	logic [kpi_pkg::DIV_NW-1:0] div_quo;
	logic [kpi_pkg::DIV_DW-1:0] div_rem;
	logic                       div_done;
	logic [31:0]                abs_t;
	logic [31:0]                abs_dur;
	logic signed [32:0]         span_t;
	logic signed [32:0]         span_k;

	assign vec_in[0] = vec_x;
	assign vec_in[1] = vec_y;
	assign vec_in[2] = vec_z;

	always_comb begin
		unique case (cmd.rd_sel)
			kpi_pkg::RD_I:    rd_addr = i_q[AW-1:0];
			kpi_pkg::RD_B:    rd_addr = b_q[AW-1:0];
			kpi_pkg::RD_ZERO: rd_addr = '0;
			default:          rd_addr = '0;
		endcase
	end

	assign lane_we    = cmd.add_key | cmd.key_wr;
	assign lane_waddr = cmd.add_key ? count_q[AW-1:0] : i_q[AW-1:0];

	kpi_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time_ram (
		.clk   (clk),
		.we    (cmd.add_key),
		.waddr (count_q[AW-1:0]),
		.wdata (t_q),
		.raddr (rd_addr),
		.rdata (time_rd)
	);

	for (genvar l = 0; l < 3; l++) begin : g_lane
		kpi_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_pos_ram (
			.clk   (clk),
			.we    (lane_we),
			.waddr (lane_waddr),
			.wdata (cmd.add_key ? vec_q[l] : lane_res[l]),
			.raddr (rd_addr),
			.rdata (ram_rd[l])
		);
		assign lane_res[l] = kpi_pkg::sat_round(prod_s1[l], add_s1[l]);
	end

	// operand selection per lane
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			case (cmd.mul_src)
				kpi_pkg::SRC_CUR:  mul_a[l] = 33'(cur_q[l]);
				kpi_pkg::SRC_DIFF: mul_a[l] = diff_q[l];
				default:           mul_a[l] = 33'(ram_rd[l]);
			endcase
			case (cmd.mul_b)
				kpi_pkg::B_ONE:   mul_b[l] = kpi_pkg::Q_ONE;
				kpi_pkg::B_RATIO: mul_b[l] = $signed({16'b0, r_q});
				default:          mul_b[l] = 33'(vec_q[l]);
			endcase
			case (cmd.mul_add)
				kpi_pkg::ADD_VEC: mul_c[l] = 33'(vec_q[l]);
				kpi_pkg::ADD_P0:  mul_c[l] = 33'(p0_q[l]);
				default:          mul_c[l] = '0;
			endcase
		end
	end

	assign abs_t   = t_q[31] ? 32'(-t_q) : 32'(t_q);
	assign abs_dur = dur_q[31] ? 32'(-dur_q) : 32'(dur_q);
	assign span_t  = 33'(t_q) - 33'(tb_q);
	assign span_k  = 33'(time_rd) - 33'(tb_q);
	assign div_num = cmd.div_mod ? {17'b0, abs_t} : {span_t, 16'b0};
	assign div_den = cmd.div_mod ? {1'b0, abs_dur} : span_k;

	kpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_mod | cmd.div_ratio),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q  <= 1'b0;
			count_q <= '0;
			for (int l = 0; l < 3; l++) begin
				cur_q[l] <= 32'(kpi_pkg::Q_ONE);
			end
		end else begin
			if (cfg_we) begin
				loop_q <= cfg_wdata;
			end
			if (cmd.clr_keys) begin
				count_q <= '0;
			end else if (cmd.add_key) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.cur_wr) begin
				for (int l = 0; l < 3; l++) begin
					cur_q[l] <= lane_res[l];
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			t_q      <= time_value;
			status_q <= kpi_pkg::ST_OK;
			for (int l = 0; l < 3; l++) begin
				vec_q[l] <= vec_in[l];
			end
		end
		if (cmd.st_en) begin
			status_q <= cmd.st;
		end
		if (cmd.add_key) begin
			dur_q <= t_q;
		end
		if (cmd.mod_done) begin
			t_q <= t_q[31] ? -$signed(div_rem[31:0]) : $signed(div_rem[31:0]);
		end
		if (cmd.ratio_done) begin
			r_q <= div_quo[16:0];
		end
		if (cmd.idx_clr) begin
			i_q <= '0;
		end else if (cmd.idx_one) begin
			i_q <= CW'(1);
			b_q <= '0;
		end else if (cmd.idx_inc) begin
			i_q <= i_q + CW'(1);
		end
		if (cmd.b_take) begin
			b_q  <= i_q;
			tb_q <= time_rd;
		end else if (cmd.tb_load) begin
			tb_q <= time_rd;
		end
		for (int l = 0; l < 3; l++) begin
			if (cmd.mul_en) begin
				prod_s1[l] <= mul_a[l] * mul_b[l];
				add_s1[l]  <= mul_c[l];
			end
			if (cmd.p0_load) begin
				p0_q[l] <= ram_rd[l];
			end
			if (cmd.diff_load) begin
				diff_q[l] <= 33'(ram_rd[l]) - 33'(p0_q[l]);
			end
		end
		if (cmd.res_load) begin
			pos_x     <= cur_q[0];
			pos_y     <= cur_q[1];
			pos_z     <= cur_q[2];
			status    <= status_q;
			duration  <= (count_q == '0) ? 32'sd0 : dur_q;
			key_count <= kpi_pkg::KEY_COUNT_W'(count_q);
		end
	end

	always_comb begin
		stat.func         = func_q;
		stat.empty        = count_q == '0;
		stat.full         = count_q == CW'(MAX_KEYS);
		stat.single       = count_q == CW'(1);
		stat.last_i       = i_q == (count_q - CW'(1));
		stat.loop_wrap    = loop_q && (dur_q != 32'sd0);
		stat.div_done     = div_done;
		stat.before_first = time_rd > t_q;
		stat.bracket      = (tb_q <= t_q) && (time_rd >= t_q);
		stat.zero_span    = time_rd == tb_q;
	end

	`KPI_ASSERT_IMPL(a_key_wr_in_table, clk, arst_n, cmd.key_wr, i_q < count_q, "key rewrite beyond table")
	`KPI_ASSERT_IMPL(a_add_not_full, clk, arst_n, cmd.add_key, count_q < CW'(MAX_KEYS), "append to full table")
	`KPI_ASSERT_IMPL(a_ratio_le_one, clk, arst_n, cmd.ratio_done, div_quo <= 49'd65536, "ratio above one")
endmodule

// ----- rtl/kpi_ctrl.sv -----
// ----------------------------------------------------------------------------
// kpi_ctrl
// sequencer for clear, append, evaluate, offset and scale
// ----------------------------------------------------------------------------
`include "keyframe_point_interpolator_macros.svh"

module kpi_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  kpi_pkg::stat_t stat,
	output kpi_pkg::cmd_t  cmd
);
	kpi_pkg::state_t state_q;
	kpi_pkg::state_t state_d;
	logic            out_valid_q;
	logic            slot_free;
	logic            is_scale;

	assign slot_free = !out_valid_q || out_ready;
	assign is_scale  = stat.func == kpi_pkg::FN_SCALE;
	assign in_ready  = state_q == kpi_pkg::S_IDLE;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kpi_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == kpi_pkg::S_FINISH && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kpi_pkg::S_IDLE: begin
				if (in_valid) state_d = kpi_pkg::S_DECODE;
			end
			kpi_pkg::S_DECODE: begin
				unique case (stat.func)
					kpi_pkg::FN_EVAL: begin
						if (stat.empty) state_d = kpi_pkg::S_FINISH;
						else if (stat.loop_wrap) state_d = kpi_pkg::S_MOD;
						else state_d = kpi_pkg::S_T0_RD;
					end
					kpi_pkg::FN_OFFSET, kpi_pkg::FN_SCALE: begin
						state_d = stat.empty ? kpi_pkg::S_PT_MUL : kpi_pkg::S_KEY_RD;
					end
					default: state_d = kpi_pkg::S_FINISH;
				endcase
			end
			kpi_pkg::S_MOD: begin
				if (stat.div_done) state_d = kpi_pkg::S_T0_RD;
			end
			kpi_pkg::S_T0_RD: state_d = kpi_pkg::S_T0_CHK;
			kpi_pkg::S_T0_CHK: begin
				if (stat.before_first) state_d = kpi_pkg::S_FINISH;
				else if (stat.single) state_d = kpi_pkg::S_HOLD_RD;
				else state_d = kpi_pkg::S_SCAN_RD;
			end
			kpi_pkg::S_SCAN_RD: state_d = kpi_pkg::S_SCAN_CHK;
			kpi_pkg::S_SCAN_CHK: begin
				if (stat.bracket) begin
					state_d = stat.zero_span ? kpi_pkg::S_HOLD_RD : kpi_pkg::S_RATIO;
				end else if (stat.last_i) begin
					state_d = kpi_pkg::S_HOLD_RD;
				end else begin
					state_d = kpi_pkg::S_SCAN_RD;
				end
			end
			kpi_pkg::S_RATIO: begin
				if (stat.div_done) state_d = kpi_pkg::S_P0_RD;
			end
			kpi_pkg::S_P0_RD:    state_d = kpi_pkg::S_P0_LD;
			kpi_pkg::S_P0_LD:    state_d = kpi_pkg::S_P1_LD;
			kpi_pkg::S_P1_LD:    state_d = kpi_pkg::S_LERP_MUL;
			kpi_pkg::S_LERP_MUL: state_d = kpi_pkg::S_CUR_WR;
			kpi_pkg::S_HOLD_RD:  state_d = kpi_pkg::S_HOLD_LD;
			kpi_pkg::S_HOLD_LD:  state_d = kpi_pkg::S_CUR_WR;
			kpi_pkg::S_KEY_RD:   state_d = kpi_pkg::S_KEY_LD;
			kpi_pkg::S_KEY_LD:   state_d = kpi_pkg::S_KEY_WR;
			kpi_pkg::S_KEY_WR: begin
				state_d = stat.last_i ? kpi_pkg::S_PT_MUL : kpi_pkg::S_KEY_RD;
			end
			kpi_pkg::S_PT_MUL: state_d = kpi_pkg::S_CUR_WR;
			kpi_pkg::S_CUR_WR: state_d = kpi_pkg::S_FINISH;
			kpi_pkg::S_FINISH: begin
				if (slot_free) state_d = kpi_pkg::S_IDLE;
			end
			default: state_d = kpi_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			kpi_pkg::S_IDLE: begin
				cmd.load = in_valid;
			end
			kpi_pkg::S_DECODE: begin
				unique case (stat.func)
					kpi_pkg::FN_CLEAR: cmd.clr_keys = 1'b1;
					kpi_pkg::FN_ADD: begin
						if (stat.full) begin
							cmd.st_en = 1'b1;
							cmd.st    = kpi_pkg::ST_FULL;
						end else begin
							cmd.add_key = 1'b1;
						end
					end
					kpi_pkg::FN_EVAL: begin
						if (stat.empty) begin
							cmd.st_en = 1'b1;
							cmd.st    = kpi_pkg::ST_EMPTY;
						end else begin
							cmd.div_mod = stat.loop_wrap;
						end
					end
					kpi_pkg::FN_OFFSET, kpi_pkg::FN_SCALE: cmd.idx_clr = 1'b1;
					default: ;
				endcase
			end
			kpi_pkg::S_MOD: begin
				cmd.mod_done = stat.div_done;
			end
			kpi_pkg::S_T0_RD: begin
				cmd.rd_sel  = kpi_pkg::RD_ZERO;
				cmd.idx_one = 1'b1;
			end
			kpi_pkg::S_T0_CHK: begin
				cmd.tb_load = 1'b1;
				if (stat.before_first) begin
					cmd.st_en = 1'b1;
					cmd.st    = kpi_pkg::ST_BEFORE;
				end
			end
			kpi_pkg::S_SCAN_RD: cmd.rd_sel = kpi_pkg::RD_I;
			kpi_pkg::S_SCAN_CHK: begin
				if (stat.bracket) begin
					cmd.div_ratio = !stat.zero_span;
				end else begin
					cmd.b_take  = 1'b1;
					cmd.idx_inc = !stat.last_i;
				end
			end
			kpi_pkg::S_RATIO: begin
				cmd.ratio_done = stat.div_done;
			end
			kpi_pkg::S_P0_RD: cmd.rd_sel = kpi_pkg::RD_B;
			kpi_pkg::S_P0_LD: begin
				cmd.p0_load = 1'b1;
				cmd.rd_sel  = kpi_pkg::RD_I;
			end
			kpi_pkg::S_P1_LD: cmd.diff_load = 1'b1;
			kpi_pkg::S_LERP_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_src = kpi_pkg::SRC_DIFF;
				cmd.mul_b   = kpi_pkg::B_RATIO;
				cmd.mul_add = kpi_pkg::ADD_P0;
			end
			kpi_pkg::S_HOLD_RD: cmd.rd_sel = kpi_pkg::RD_B;
			kpi_pkg::S_HOLD_LD: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_src = kpi_pkg::SRC_RAM;
				cmd.mul_b   = kpi_pkg::B_ONE;
				cmd.mul_add = kpi_pkg::ADD_ZERO;
			end
			kpi_pkg::S_KEY_RD: cmd.rd_sel = kpi_pkg::RD_I;
			kpi_pkg::S_KEY_LD: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_src = kpi_pkg::SRC_RAM;
				cmd.mul_b   = is_scale ? kpi_pkg::B_VEC : kpi_pkg::B_ONE;
				cmd.mul_add = is_scale ? kpi_pkg::ADD_ZERO : kpi_pkg::ADD_VEC;
			end
			kpi_pkg::S_KEY_WR: begin
				cmd.key_wr  = 1'b1;
				cmd.idx_inc = !stat.last_i;
			end
			kpi_pkg::S_PT_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_src = kpi_pkg::SRC_CUR;
				cmd.mul_b   = is_scale ? kpi_pkg::B_VEC : kpi_pkg::B_ONE;
				cmd.mul_add = is_scale ? kpi_pkg::ADD_ZERO : kpi_pkg::ADD_VEC;
			end
			kpi_pkg::S_CUR_WR: cmd.cur_wr = 1'b1;
			kpi_pkg::S_FINISH: cmd.res_load = slot_free;
			default: ;
		endcase
	end

	`KPI_ASSERT_IMPL(a_div_done_waited, clk, arst_n, stat.div_done, state_q == kpi_pkg::S_MOD || state_q == kpi_pkg::S_RATIO, "divider done while not waiting")
	`KPI_ASSERT_NEXT(a_accept_decodes, clk, arst_n, in_valid && in_ready, state_q == kpi_pkg::S_DECODE, "accepted item not decoded")
	`KPI_ASSERT_IMPL(a_result_from_finish, clk, arst_n, $rose(out_valid_q), $past(state_q) == kpi_pkg::S_FINISH, "result without finish")
endmodule

// ----- rtl/keyframe_point_interpolator.sv -----
// ----------------------------------------------------------------------------
// keyframe_point_interpolator
// keyframe table of timed 3d points with linear evaluation, offset and scale
// ----------------------------------------------------------------------------
// One item is handled at a time and each gives one result item; the next item
// can be taken while the previous result still waits in the output register.
// Offset and scale run every stored key through the shared multiply lanes.
// Evaluate scans the time memory key by key and uses the one bit-per-cycle
// divider for the loop wrap remainder and for the interpolation ratio.
// Key memories have no reset, only the key count does, so the block is
// ready right after reset.
// ----------------------------------------------------------------------------
module keyframe_point_interpolator #(
	parameter int MAX_KEYS = kpi_pkg::MAX_KEYS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	kpi_item_if.sink     item,
	kpi_result_if.source result,
	input logic          cfg_we,
	input logic          cfg_wdata
);
	// command and status between sequencer and datapath
	kpi_pkg::cmd_t  cmd;
	kpi_pkg::stat_t stat;

	// sequencer: owns the item handshake and the result valid flag
	kpi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: key memories, point, loop flag and the result register
	kpi_datapath #(.MAX_KEYS(MAX_KEYS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.func       (item.func),
		.time_value (item.time_value),
		.vec_x      (item.vec_x),
		.vec_y      (item.vec_y),
		.vec_z      (item.vec_z),
		.pos_x      (result.pos_x),
		.pos_y      (result.pos_y),
		.pos_z      (result.pos_z),
		.status     (result.status),
		.duration   (result.duration),
		.key_count  (result.key_count)
	);
endmodule

// ----- bench/kpi_scoreboard.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpi_scoreboard
// watches the item, result and register ports of the keyframe point
// interpolator, keeps its own copy of the key table and the current point,
// and checks every result item field by field against the oldest expectation
// ----------------------------------------------------------------------------
module kpi_scoreboard (
	input  logic  clk,
	input  logic  arst_n,
	kpi_item_if   item,
	kpi_result_if result,
	input  logic  cfg_we,
	input  logic  cfg_wdata,
	output int    fails,
	output int    pending,
	output int    results_seen
);

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [1:0]         st;
		logic signed [31:0] dur;
		logic [6:0]         cnt;
	} point_result_t;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	longint        trk_time [kpi_pkg::MAX_KEYS_DEF];
	longint        trk_x [kpi_pkg::MAX_KEYS_DEF];
	longint        trk_y [kpi_pkg::MAX_KEYS_DEF];
	longint        trk_z [kpi_pkg::MAX_KEYS_DEF];
	int            trk_count;
	longint        pt_x, pt_y, pt_z;
	bit            wrap_on;
	point_result_t point_q[$];

	function automatic longint clamp32(longint v);
		if (v > S32_MAX) return S32_MAX;
		if (v < S32_MIN) return S32_MIN;
		return v;
	endfunction

	function automatic longint fix_mul(longint a, longint b);
		return clamp32((a * b) / 65536);
	endfunction

	function automatic longint blend(longint p0, longint p1, longint r);
		return clamp32(p0 + ((p1 - p0) * r) / 65536);
	endfunction

	function automatic logic [1:0] sample_track(longint t_in);
		longint t, span, r;
		int     lo, hi;
		bit     found_pair;
		t = t_in;
		lo = 0;
		hi = 0;
		found_pair = 0;
		if (trk_count == 0) return kpi_pkg::ST_EMPTY;
		if (wrap_on && trk_time[trk_count-1] != 0) t = t % trk_time[trk_count-1];
		if (trk_time[0] > t) return kpi_pkg::ST_BEFORE;
		for (int i = 1; i < trk_count; i++) begin
			hi = i;
			found_pair = 1;
			if (trk_time[lo] <= t && trk_time[hi] >= t) break;
			lo = hi;
		end
		span = trk_time[hi] - trk_time[lo];
		if (!found_pair || span == 0) begin
			pt_x = trk_x[lo];
			pt_y = trk_y[lo];
			pt_z = trk_z[lo];
		end else begin
			r = ((t - trk_time[lo]) * 65536) / span;
			pt_x = blend(trk_x[lo], trk_x[hi], r);
			pt_y = blend(trk_y[lo], trk_y[hi], r);
			pt_z = blend(trk_z[lo], trk_z[hi], r);
		end
		return kpi_pkg::ST_OK;
	endfunction

	function automatic point_result_t apply_item(logic [2:0] f, longint t, longint vx,
			longint vy, longint vz);
		point_result_t res;
		res.st = kpi_pkg::ST_OK;
		if (f == kpi_pkg::FN_CLEAR) begin
			trk_count = 0;
		end else if (f == kpi_pkg::FN_ADD) begin
			if (trk_count >= kpi_pkg::MAX_KEYS_DEF) begin
				res.st = kpi_pkg::ST_FULL;
			end else begin
				trk_time[trk_count] = t;
				trk_x[trk_count] = vx;
				trk_y[trk_count] = vy;
				trk_z[trk_count] = vz;
				trk_count++;
			end
		end else if (f == kpi_pkg::FN_EVAL) begin
			res.st = sample_track(t);
		end else if (f == kpi_pkg::FN_OFFSET) begin
			for (int i = 0; i < trk_count; i++) begin
				trk_x[i] = clamp32(trk_x[i] + vx);
				trk_y[i] = clamp32(trk_y[i] + vy);
				trk_z[i] = clamp32(trk_z[i] + vz);
			end
			pt_x = clamp32(pt_x + vx);
			pt_y = clamp32(pt_y + vy);
			pt_z = clamp32(pt_z + vz);
		end else if (f == kpi_pkg::FN_SCALE) begin
			for (int i = 0; i < trk_count; i++) begin
				trk_x[i] = fix_mul(trk_x[i], vx);
				trk_y[i] = fix_mul(trk_y[i], vy);
				trk_z[i] = fix_mul(trk_z[i], vz);
			end
			pt_x = fix_mul(pt_x, vx);
			pt_y = fix_mul(pt_y, vy);
			pt_z = fix_mul(pt_z, vz);
		end
		res.x = pt_x[31:0];
		res.y = pt_y[31:0];
		res.z = pt_z[31:0];
		res.dur = trk_count ? trk_time[trk_count-1][31:0] : 32'sd0;
		res.cnt = trk_count[6:0];
		return res;
	endfunction

	assign pending = point_q.size();

	always @(posedge clk or negedge arst_n) begin
		point_result_t want;
		if (!arst_n) begin
			trk_count = 0;
			pt_x = 65536;
			pt_y = 65536;
			pt_z = 65536;
			wrap_on = 0;
			fails = 0;
			results_seen = 0;
			point_q.delete();
		end else begin
			// result side first: an item taken this edge cannot have its result out yet
			if (result.valid && result.ready) begin
				results_seen++;
				if (point_q.size() == 0) begin
					fails++;
					if (fails <= 10) $display("unexpected result item at %0t", $realtime);
				end else begin
					want = point_q.pop_front();
					if (result.pos_x !== want.x || result.pos_y !== want.y ||
							result.pos_z !== want.z || result.status !== want.st ||
							result.duration !== want.dur || result.key_count !== want.cnt) begin
						fails++;
						if (fails <= 10) begin
							$display("mismatch at %0t: exp x=%h y=%h z=%h st=%0d dur=%h n=%0d",
								$realtime, want.x, want.y, want.z, want.st, want.dur, want.cnt);
							$display("                  got x=%h y=%h z=%h st=%0d dur=%h n=%0d",
								result.pos_x, result.pos_y, result.pos_z, result.status,
								result.duration, result.key_count);
						end
					end
				end
			end
			if (item.valid && item.ready)
				point_q.push_back(apply_item(item.func, longint'(item.time_value),
					longint'(item.vec_x), longint'(item.vec_y), longint'(item.vec_z)));
			if (cfg_we) wrap_on = cfg_wdata;
		end
	end

endmodule

// ----- bench/keyframe_point_interpolator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_point_interpolator_tb
// drives clear, append, evaluate, offset and scale items into the block,
// with and without time wrapping, random stalls on both channels and a long
// output hold-off; the scoreboard predicts and checks every result item
// ----------------------------------------------------------------------------
module keyframe_point_interpolator_tb;

	localparam int         ITEM_GOAL   = 800;
	localparam int         DRAIN_WAIT  = 260;
	localparam int         STALL_LIMIT = 5000;  // cycles with no item moving at all
	localparam int         HOLD_CYCLES = 400;
	localparam logic [2:0] FN_SPARE    = 3'd5;  // codes from here up do nothing
	localparam int         S32_MAX     = 32'sh7FFFFFFF;
	localparam int         S32_MIN     = 32'sh80000000;
	localparam int         Q_UNIT      = 65536;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_wdata = 0;

	kpi_item_if   item_ch ();
	kpi_result_if result_ch ();

	int  fails, pending, results_seen;
	int  items_sent = 0;
	int  evals_sent = 0;
	int  phases_run = 0;
	int  quiet_cycles = 0;
	bit  idle_on = 1;     // random gaps on both channels
	bit  hold_req = 0;    // asks the receiver for one long hold-off

	always #1 clk = ~clk;

	keyframe_point_interpolator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	kpi_scoreboard chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.fails       (fails),
		.pending     (pending),
		.results_seen(results_seen)
	);

	// watchdog: any accepted item on either channel restarts the count
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result receiver: random stall bursts, plus the one long hold-off on request
	initial begin
		result_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_ch.ready = 0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				result_ch.ready = 0;
				repeat ($urandom_range(0, 13)) @(negedge clk);
			end else begin
				result_ch.ready = 1;
			end
		end
	end

	// one item on the input channel, optionally after a random gap
	task automatic put_item(logic [2:0] f, int t, int x, int y, int z);
		if (idle_on && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 14)) @(negedge clk);
		item_ch.valid = 1;
		item_ch.func = f;
		item_ch.time_value = t;
		item_ch.vec_x = x;
		item_ch.vec_y = y;
		item_ch.vec_z = z;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		item_ch.valid = 0;
		items_sent++;
		if (f == kpi_pkg::FN_EVAL) evals_sent++;
	endtask

	// sender pause until every result is back, then let the block settle
	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic set_wrap(bit on);
		drain();
		cfg_we = 1;
		cfg_wdata = on;
		@(negedge clk);
		cfg_we = 0;
	endtask

	function automatic int any_word();
		return $urandom();
	endfunction

	// point component: mostly moderate, sometimes anything at all
	function automatic int coord();
		if ($urandom_range(0, 4) == 0) return $urandom();
		return $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
	endfunction

	// builds a track of sorted key times and exercises it
	task automatic run_track(int n_keys);
		int t_first, t_cur, span, t_eval, n_ops;
		t_first = $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
		if ($urandom_range(0, 5) == 0) t_first = 0;
		t_cur = t_first;
		put_item(kpi_pkg::FN_CLEAR, any_word(), any_word(), any_word(), any_word());
		for (int i = 0; i < n_keys; i++) begin
			put_item(kpi_pkg::FN_ADD, t_cur, coord(), coord(), coord());
			// zero spacing now and then
			if ($urandom_range(0, 6) != 0) t_cur += $urandom_range(1, 32'h000FFFFF);
		end
		span = t_cur - t_first + 1;
		n_ops = $urandom_range(4, 12);
		for (int k = 0; k < n_ops; k++) begin
			case ($urandom_range(0, 11))
				0: put_item(kpi_pkg::FN_OFFSET, any_word(), coord(), coord(), coord());
				1: put_item(kpi_pkg::FN_SCALE, any_word(),
					Q_UNIT + $signed($urandom_range(0, 32'h0001FFFF)) - 32'sh00010000,
					$urandom_range(0, 3) == 0 ? any_word() : Q_UNIT,
					-Q_UNIT);
				2: put_item(kpi_pkg::FN_EVAL, any_word(), any_word(), any_word(), any_word());
				3: put_item(3'(FN_SPARE + $urandom_range(0, 2)), any_word(), any_word(),
					any_word(), any_word());
				4: put_item(kpi_pkg::FN_ADD, t_cur + $urandom_range(0, 32'hFFFF), coord(),
					coord(), coord());
				default: begin
					t_eval = t_first - span / 4 + $urandom_range(0, span + span / 2);
					if ($urandom_range(0, 4) == 0) t_eval = -t_eval;
					put_item(kpi_pkg::FN_EVAL, t_eval, any_word(), any_word(), any_word());
				end
			endcase
		end
	endtask

	initial begin
		item_ch.valid = 0;
		item_ch.func = kpi_pkg::FN_CLEAR;
		item_ch.time_value = 0;
		item_ch.vec_x = 0;
		item_ch.vec_y = 0;
		item_ch.vec_z = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty table, before first key, single key, zero spacing,
		// interpolation across the full range, past the end, saturating offset
		// and scale, unused codes, clear
		set_wrap(0);
		put_item(kpi_pkg::FN_EVAL, 0, 0, 0, 0);
		put_item(kpi_pkg::FN_ADD, Q_UNIT, S32_MAX, S32_MIN, 0);
		put_item(kpi_pkg::FN_EVAL, 0, 0, 0, 0);
		put_item(kpi_pkg::FN_EVAL, Q_UNIT, 0, 0, 0);
		put_item(kpi_pkg::FN_ADD, Q_UNIT, 0, S32_MAX, -1);
		put_item(kpi_pkg::FN_EVAL, Q_UNIT, 0, 0, 0);
		put_item(kpi_pkg::FN_ADD, 3 * Q_UNIT, S32_MIN, S32_MAX, S32_MAX);
		put_item(kpi_pkg::FN_EVAL, 2 * Q_UNIT, 0, 0, 0);
		put_item(kpi_pkg::FN_EVAL, 3 * Q_UNIT - 1, 0, 0, 0);
		put_item(kpi_pkg::FN_EVAL, S32_MAX, 0, 0, 0);
		put_item(kpi_pkg::FN_EVAL, S32_MIN, 0, 0, 0);
		put_item(kpi_pkg::FN_OFFSET, 0, S32_MAX, S32_MIN, Q_UNIT);
		put_item(kpi_pkg::FN_SCALE, 0, S32_MIN, S32_MAX, 0);
		put_item(kpi_pkg::FN_SCALE, 0, -Q_UNIT, S32_MIN, S32_MAX);
		put_item(kpi_pkg::FN_EVAL, 2 * Q_UNIT + 3, 0, 0, 0);
		for (int c = 0; c < 3; c++) put_item(3'(FN_SPARE + c), -1, -1, -1, -1);
		put_item(kpi_pkg::FN_CLEAR, -1, -1, -1, -1);
		put_item(kpi_pkg::FN_EVAL, Q_UNIT, 0, 0, 0);

		// directed wrap: negative times keep their sign, zero end time skips wrap
		set_wrap(1);
		put_item(kpi_pkg::FN_ADD, 0, Q_UNIT, 0, 0);
		put_item(kpi_pkg::FN_EVAL, 5 * Q_UNIT, 0, 0, 0);
		put_item(kpi_pkg::FN_ADD, 4 * Q_UNIT, 0, Q_UNIT, 0);
		put_item(kpi_pkg::FN_EVAL, 9 * Q_UNIT + 7, 0, 0, 0);
		put_item(kpi_pkg::FN_EVAL, -5 * Q_UNIT, 0, 0, 0);
		put_item(kpi_pkg::FN_EVAL, S32_MIN, 0, 0, 0);

		// fill the table past its end with the wrap on
		run_track(kpi_pkg::MAX_KEYS_DEF + 2);

		// random phases, alternating the wrap setting
		while (items_sent < ITEM_GOAL) begin
			set_wrap(phases_run % 2);
			phases_run++;
			// one long output hold-off while items keep coming
			if (phases_run == 3) hold_req = 1;
			// final stretch runs with no gaps on either side
			if (items_sent > ITEM_GOAL - 120) idle_on = 0;
			for (int k = 0; k < 4; k++)
				run_track($urandom_range(0, 9) == 0 ? $urandom_range(20, 40) :
					$urandom_range(1, 8));
		end

		drain();
		$display("covered %0d items (%0d evaluations) in %0d phases with wrap on and off,",
			items_sent, evals_sent, phases_run + 2);
		$display("a full key table, saturating offset and scale, and %0d results checked",
			results_seen);
		if (fails == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/kpi_pkg.sv
rtl/kpi_if.sv
rtl/kpi_ram.sv
rtl/kpi_div.sv
rtl/kpi_datapath.sv
rtl/kpi_ctrl.sv
rtl/keyframe_point_interpolator.sv
bench/kpi_scoreboard.sv
bench/keyframe_point_interpolator_tb.sv
